// ----- src/tcc_pkg.sv -----
// Shared types, constants and codes for the text console block.
package tcc_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int CUR_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef enum logic [2:0] {
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_BACKSPACE,
        CMD_CHAR,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              idx_ok;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

// ----- src/tcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcc_ram
    import tcc_pkg::*;
#(
    parameter int WIDTH = CELL_W,
    parameter int DEPTH = DEF_COLUMNS * DEF_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/tcc_front.sv -----
// Front end: accepts items, decodes them into commands, two-entry command queue.
module tcc_front
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [IDX_W-1:0]  i_idx,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output t_cmd              o_q_cmd
);

    localparam int CELLS = COLUMNS * ROWS;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;
    logic       pop;

    always_comb begin
        dec.ch     = i_char;
        dec.idx    = i_idx;
        dec.idx_ok = (32'(i_idx) < CELLS);
        case (i_action)
            ACT_PUT: begin
                if (i_char == CH_NEWLINE) begin
                    dec.kind = CMD_NEWLINE;
                end else if (i_char == CH_RETURN) begin
                    dec.kind = CMD_RETURN;
                end else if (i_char == CH_BACKSPACE) begin
                    dec.kind = CMD_BACKSPACE;
                end else begin
                    dec.kind = CMD_CHAR;
                end
            end
            ACT_CLEAR: dec.kind = CMD_CLEAR;
            ACT_READ:  dec.kind = CMD_READ;
            default:   dec.kind = CMD_NOP;
        endcase
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_cmd   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/tcc_back.sv -----
// Back end: cursor, screen memory sequencer (fill, scroll copy, blank) and result register.
module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ATTR_W-1:0] i_attr,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_cmd              i_q_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CUR_W-1:0]  o_cursor,
    output logic [CELL_W-1:0] o_rd_data,
    output logic              o_scrolled
);

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int POS_W     = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

    t_state            r_state;
    t_state            n_state;
    logic [POS_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_src;
    logic              r_cp_v;
    logic [POS_W-1:0]  r_cp_dst;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [POS_W-1:0]  r_pos;
    logic [CELL_W-1:0] r_pend_rd;
    logic              r_pend_scr;
    logic              r_out_v;
    logic [CUR_W-1:0]  r_out_cur;
    logic [CELL_W-1:0] r_out_rd;
    logic              r_out_scr;

    logic [ROW_W-1:0]  s_row;
    logic [COL_W-1:0]  s_col;
    logic [POS_W-1:0]  s_pos;
    logic              s_scroll;
    logic              can_out;
    logic              pop;
    logic              go_multi;
    logic              load_out;
    logic              col_last;
    logic              row_last;
    logic              sweep_end;

    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic [CELL_W-1:0] rd_data;

    tcc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign can_out   = !r_out_v || i_ready;
    assign o_q_ready = (r_state == ST_IDLE) && can_out;
    assign pop       = i_q_valid && o_q_ready;
    assign col_last  = (r_col == COL_W'(COLUMNS - 1));
    assign row_last  = (r_row == ROW_W'(ROWS - 1));
    assign sweep_end = (r_cnt == POS_W'(CELLS - 1));

    // cursor step for the command at the head of the queue
    always_comb begin
        s_row    = r_row;
        s_col    = r_col;
        s_pos    = r_pos;
        s_scroll = 1'b0;
        case (i_q_cmd.kind)
            CMD_NEWLINE: begin
                s_col = '0;
                if (row_last) begin
                    s_scroll = 1'b1;
                    s_pos    = POS_W'(LAST_BASE);
                end else begin
                    s_row = r_row + ROW_W'(1);
                    s_pos = r_pos - POS_W'(r_col) + POS_W'(COLUMNS);
                end
            end
            CMD_RETURN: begin
                s_col = '0;
                s_pos = r_pos - POS_W'(r_col);
            end
            CMD_BACKSPACE: begin
                if (r_col != '0) begin
                    s_col = r_col - COL_W'(1);
                    s_pos = r_pos - POS_W'(1);
                end
            end
            CMD_CHAR: begin
                if (col_last) begin
                    s_col = '0;
                    if (row_last) begin
                        s_scroll = 1'b1;
                        s_pos    = POS_W'(LAST_BASE);
                    end else begin
                        s_row = r_row + ROW_W'(1);
                        s_pos = r_pos + POS_W'(1);
                    end
                end else begin
                    s_col = r_col + COL_W'(1);
                    s_pos = r_pos + POS_W'(1);
                end
            end
            CMD_CLEAR: begin
                s_row = '0;
                s_col = '0;
                s_pos = '0;
            end
            default: begin
                s_row = r_row;
            end
        endcase
    end

    assign go_multi = s_scroll || (i_q_cmd.kind == CMD_CLEAR)
                    || ((i_q_cmd.kind == CMD_READ) && i_q_cmd.idx_ok);
    assign load_out = (pop && !go_multi) || ((r_state == ST_DONE) && can_out);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (sweep_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    if (i_q_cmd.kind == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else if ((i_q_cmd.kind == CMD_READ) && i_q_cmd.idx_ok) begin
                        n_state = ST_READ;
                    end else if (s_scroll) begin
                        n_state = ST_SCROLL;
                    end
                end
            end
            ST_READ: n_state = ST_DONE;
            ST_SCROLL: begin
                if (r_src == POS_W'(CELLS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_BLANK;
            ST_BLANK, ST_CLEAR: begin
                if (sweep_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (can_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cnt;
        wr_data = {i_attr, CH_SPACE};
        rd_en   = 1'b0;
        rd_addr = r_src;
        case (r_state)
            ST_INIT: begin
                wr_en   = 1'b1;
                wr_data = RESET_CELL;
            end
            ST_IDLE: begin
                if (pop && (i_q_cmd.kind == CMD_CHAR)) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos;
                    wr_data = {i_attr, i_q_cmd.ch};
                end
                if (pop && (i_q_cmd.kind == CMD_READ) && i_q_cmd.idx_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = POS_W'(i_q_cmd.idx);
                end
            end
            ST_SCROLL: begin
                rd_en   = 1'b1;
                wr_en   = r_cp_v;
                wr_addr = r_cp_dst;
                wr_data = rd_data;
            end
            ST_DRAIN: begin
                wr_en   = 1'b1;
                wr_addr = r_cp_dst;
                wr_data = rd_data;
            end
            ST_BLANK, ST_CLEAR: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_INIT;
            r_cnt      <= '0;
            r_cp_v     <= 1'b0;
            r_row      <= '0;
            r_col      <= '0;
            r_pos      <= '0;
            r_out_v    <= 1'b0;
            r_pend_scr <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_INIT, ST_BLANK, ST_CLEAR: r_cnt <= r_cnt + POS_W'(1);
                ST_DRAIN:                    r_cnt <= POS_W'(LAST_BASE);
                ST_IDLE:                     r_cnt <= '0;
                default:                     r_cnt <= r_cnt;
            endcase
            r_cp_v <= (r_state == ST_SCROLL);
            if (pop) begin
                r_row      <= s_row;
                r_col      <= s_col;
                r_pos      <= s_pos;
                r_pend_scr <= s_scroll;
            end
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_src     <= POS_W'(COLUMNS);
            r_pend_rd <= '0;
        end else if (r_state == ST_SCROLL) begin
            r_src <= r_src + POS_W'(1);
        end
        r_cp_dst <= r_src - POS_W'(COLUMNS);
        if (r_state == ST_READ) begin
            r_pend_rd <= rd_data;
        end
        if (pop && !go_multi) begin
            r_out_cur <= CUR_W'(s_pos);
            r_out_rd  <= '0;
            r_out_scr <= 1'b0;
        end else if ((r_state == ST_DONE) && can_out) begin
            r_out_cur <= CUR_W'(r_pos);
            r_out_rd  <= r_pend_rd;
            r_out_scr <= r_pend_scr;
        end
    end

    assign o_valid    = r_out_v;
    assign o_cursor   = r_out_cur;
    assign o_rd_data  = r_out_rd;
    assign o_scrolled = r_out_scr;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_W'(ROWS - 1)) && (r_col <= COL_W'(COLUMNS - 1)))
        else $error("cursor outside screen");

    a_pos_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) == (32'(r_row) * COLUMNS + 32'(r_col)))
        else $error("linear cursor out of step with row/column");

    a_copy_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("scroll copy reads and writes one cell");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && can_out) |=> (r_out_v && (r_state == ST_IDLE)))
        else $error("finished command did not reach result register");

endmodule

// ----- src/text_console_cursor_scroll.sv -----
// Top level of the text console: config register, front decoder/queue, back executor.
//
//  channel   dir  handshake                 payload
//  s_axis    in   i_s_tvalid / o_s_tready   tuser: action; tdata: char_code, cell_index
//  m_axis    out  o_m_tvalid / i_m_tready   tdata: cursor_index, read_data, scrolled
//  cfg       in   i_cfg_valid / o_cfg_ready i_cfg_data: attribute
//
//  Put of a plain char, newline, return, backspace: done in the idle state as it is taken.
//  Read: READ, then DONE (memory read is registered). Clear: CLEAR blanks all cells, DONE.
//  A put that scrolls: SCROLL copies rows up, DRAIN writes the last copy, BLANK blanks
//  the last row, DONE; one memory write per cell. After reset INIT fills the screen memory;
//  the executor takes no item then, the queue holds up to two and then stalls s_axis.
//  A two-item queue sits between decode and execute; the result register frees the
//  executor when m_axis stalls for one item.
module text_console_cursor_scroll
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [23:0]        i_s_tdata,   // [7:0] char_code, [18:8] cell_index, zero pad
    input  logic [1:0]         i_s_tuser,   // [1:0] action
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [31:0]        o_m_tdata,   // [10:0] cursor_index, [26:11] read_data,
                                            // [27] scrolled, zero pad
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [ATTR_W-1:0]  i_cfg_data
);

    logic [ATTR_W-1:0] r_attr;
    logic              q_valid;
    logic              q_ready;
    t_cmd              q_cmd;
    logic [CUR_W-1:0]  cursor;
    logic [CELL_W-1:0] rd_data;
    logic              scrolled;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    tcc_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_action  (i_s_tuser),
        .i_char    (i_s_tdata[7:0]),
        .i_idx     (i_s_tdata[18:8]),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_cmd   (q_cmd)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     (r_attr),
        .i_q_valid  (q_valid),
        .o_q_ready  (q_ready),
        .i_q_cmd    (q_cmd),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_cursor   (cursor),
        .o_rd_data  (rd_data),
        .o_scrolled (scrolled)
    );

    assign o_m_tdata = {4'b0, scrolled, rd_data, cursor};

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the text console block: directed table, random item streams.
`timescale 1ns / 100ps

module tb_top;
    import tcc_pkg::*;

    localparam int SCR_COLS  = DEF_COLUMNS;
    localparam int SCR_ROWS  = DEF_ROWS;
    localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int HOLD_CYC = 5000;
    localparam int PHASE_ITEMS = 90;

    typedef struct packed {
        logic [CUR_W-1:0]  cursor;
        logic [CELL_W-1:0] rdata;
        logic              scrolled;
    } console_res_t;

    typedef struct packed {
        logic [1:0]        act;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        logic [CUR_W-1:0]  cur;
        logic [CELL_W-1:0] rd;
        logic              sc;
    } dir_row_t;

    localparam int N_DIR = 23;
    localparam dir_row_t DIRECTED [N_DIR] = '{
        '{ACT_READ,  8'h00,        11'd0,    1'b1, 11'd0,  RESET_CELL, 1'b0},
        '{ACT_READ,  8'h00,        11'd1999, 1'b1, 11'd0,  RESET_CELL, 1'b0},
        '{ACT_READ,  8'h00,        11'd2000, 1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_READ,  8'hFF,        11'd2047, 1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_NONE,  8'hFF,        11'd2047, 1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_PUT,   CH_BACKSPACE, 11'd0,    1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_PUT,   8'h41,        11'd0,    1'b1, 11'd1,  16'h0000,   1'b0},
        '{ACT_PUT,   8'h00,        11'd2047, 1'b1, 11'd2,  16'h0000,   1'b0},
        '{ACT_PUT,   8'hFF,        11'd0,    1'b1, 11'd3,  16'h0000,   1'b0},
        '{ACT_READ,  8'h00,        11'd0,    1'b1, 11'd3,  16'h0741,   1'b0},
        '{ACT_READ,  8'h00,        11'd2,    1'b1, 11'd3,  16'h07FF,   1'b0},
        '{ACT_PUT,   CH_BACKSPACE, 11'd0,    1'b1, 11'd2,  16'h0000,   1'b0},
        '{ACT_PUT,   CH_RETURN,    11'd0,    1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_PUT,   CH_NEWLINE,   11'd0,    1'b1, 11'd80, 16'h0000,   1'b0},
        '{ACT_PUT,   CH_BACKSPACE, 11'd0,    1'b1, 11'd80, 16'h0000,   1'b0},
        '{ACT_PUT,   8'h7E,        11'd0,    1'b1, 11'd81, 16'h0000,   1'b0},
        '{ACT_READ,  8'h00,        11'd80,   1'b1, 11'd81, 16'h077E,   1'b0},
        '{ACT_READ,  8'hA5,        11'h555,  1'b0, 11'd0,  16'h0000,   1'b0},
        '{ACT_PUT,   8'h5A,        11'h2AA,  1'b0, 11'd0,  16'h0000,   1'b0},
        '{ACT_CLEAR, 8'h00,        11'd0,    1'b1, 11'd0,  16'h0000,   1'b0},
        '{ACT_READ,  8'h00,        11'd0,    1'b1, 11'd0,  RESET_CELL, 1'b0},
        '{ACT_READ,  8'h00,        11'd81,   1'b1, 11'd0,  RESET_CELL, 1'b0},
        '{ACT_NONE,  8'h00,        11'd0,    1'b1, 11'd0,  16'h0000,   1'b0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [23:0]        i_s_tdata;  // [7:0] char_code, [18:8] cell_index, zero pad
    logic [1:0]         i_s_tuser;  // [1:0] action
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [31:0]        o_m_tdata;  // [10:0] cursor_index, [26:11] read_data, [27] scrolled
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [ATTR_W-1:0]  i_cfg_data;

    text_console_cursor_scroll #(
        .COLUMNS(SCR_COLS),
        .ROWS   (SCR_ROWS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the console
    logic [CELL_W-1:0] shadow_cells [SCR_CELLS];
    int unsigned       shadow_row;
    int unsigned       shadow_col;
    logic [ATTR_W-1:0] shadow_attr;

    console_res_t console_out_q [$];

    int  fail_cnt;
    int  n_items;
    int  n_checked;
    int  n_reads;
    int  n_clears;
    int  n_scrolls;
    int  n_cfg;
    int  burst_left;
    bit  hold_req;
    bit  hold_done;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic console_step(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                                input logic [IDX_W-1:0] idx, output console_res_t res);
        int unsigned pos;
        int          i;
        logic [CELL_W-1:0] rd;
        logic              sc;
        rd = '0;
        sc = 1'b0;
        if (act == ACT_PUT) begin
            if (ch == CH_NEWLINE) begin
                shadow_col = 0;
                shadow_row++;
            end else if (ch == CH_RETURN) begin
                shadow_col = 0;
            end else if (ch == CH_BACKSPACE) begin
                if (shadow_col > 0)
                    shadow_col--;
            end else begin
                pos = shadow_row * SCR_COLS + shadow_col;
                if (pos < SCR_CELLS)
                    shadow_cells[pos] = {shadow_attr, ch};
                shadow_col++;
                if (shadow_col >= SCR_COLS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
            end
            if (shadow_row >= SCR_ROWS) begin
                for (i = 0; i < SCR_CELLS - SCR_COLS; i++)
                    shadow_cells[i] = shadow_cells[i + SCR_COLS];
                for (i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
                    shadow_cells[i] = {shadow_attr, CH_SPACE};
                shadow_row = SCR_ROWS - 1;
                sc = 1'b1;
            end
        end else if (act == ACT_CLEAR) begin
            for (i = 0; i < SCR_CELLS; i++)
                shadow_cells[i] = {shadow_attr, CH_SPACE};
            shadow_row = 0;
            shadow_col = 0;
        end else if (act == ACT_READ) begin
            if (idx < SCR_CELLS)
                rd = shadow_cells[idx];
        end
        res.cursor   = CUR_W'(shadow_row * SCR_COLS + shadow_col);
        res.rdata    = rd;
        res.scrolled = sc;
    endtask

    // offer one item, wait for it to be taken, then record what it should return
    task automatic push_item(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input bit typed,
                             input console_res_t typed_res);
        console_res_t res;
        int           gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, idx, ch};
        i_s_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        console_step(act, ch, idx, res);
        console_out_q.push_back(typed ? typed_res : res);
        n_items++;
        if (act == ACT_READ)
            n_reads++;
        if (act == ACT_CLEAR)
            n_clears++;
        if (res.scrolled)
            n_scrolls++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= 24'($urandom);
                i_s_tuser  <= 2'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic put_rand(input logic [1:0] act, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
        push_item(act, ch, idx, 1'b0, '0);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] val);
        while (console_out_q.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        shadow_attr = val;
        n_cfg++;
    endtask

    task automatic run_phase(input int target);
        int done;
        int len;
        int k;
        int sel;
        int cur;
        int back;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        done = 0;
        while (done < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                len = $urandom_range(1, 90);
                for (k = 0; k < len; k++) begin
                    case ($urandom_range(0, 19))
                        0: ch = CH_NEWLINE;
                        1: ch = CH_RETURN;
                        2: ch = CH_BACKSPACE;
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    put_rand(ACT_PUT, ch, 11'($urandom));
                end
            end else if (sel < 50) begin
                len = $urandom_range(1, 30);
                for (k = 0; k < len; k++)
                    put_rand(ACT_PUT, CH_NEWLINE, 11'($urandom));
            end else if (sel < 60) begin
                len = $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    put_rand(ACT_PUT, CH_BACKSPACE, 11'($urandom));
                put_rand(ACT_PUT, 8'($urandom_range(32, 126)), 11'($urandom));
            end else if (sel < 85) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    cur = shadow_row * SCR_COLS + shadow_col;
                    case ($urandom_range(0, 3))
                        0: begin
                            back = $urandom_range(0, 120);
                            idx = 11'((cur > back) ? cur - back : 0);
                        end
                        1: idx = 11'($urandom_range(SCR_CELLS - SCR_COLS, SCR_CELLS - 1));
                        2: idx = 11'($urandom_range(SCR_CELLS, 2047));
                        default: idx = 11'($urandom_range(0, 2047));
                    endcase
                    put_rand(ACT_READ, 8'($urandom), idx);
                end
            end else if (sel < 92) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    put_rand(2'($urandom_range(0, 3)), 8'($urandom), 11'($urandom));
            end else if (sel < 96) begin
                len = 1;
                put_rand(ACT_CLEAR, 8'($urandom), 11'($urandom));
            end else begin
                len = 1;
                put_rand(ACT_NONE, 8'($urandom), 11'($urandom));
            end
            done += len;
        end
        i_s_tvalid <= 1'b0;
    endtask

    // result side: stall pattern, plus one long hold-off on request
    initial begin
        int          stretch_left;
        int          hold_cnt;
        logic [7:0]  rdy_pat;
        i_m_tready   = 1'b0;
        stretch_left = 0;
        rdy_pat      = 8'hFF;
        hold_done    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYC) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
                hold_done = 1'b1;
            end else begin
                if (stretch_left == 0) begin
                    stretch_left = $urandom_range(16, 64);
                    rdy_pat = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                    if (rdy_pat == 8'h00)
                        rdy_pat = 8'h01;
                end
                i_m_tready <= rdy_pat[0];
                rdy_pat = {rdy_pat[0], rdy_pat[7:1]};
                stretch_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        console_res_t exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (console_out_q.size() == 0) begin
                $error("result with no item pending: tdata %h", o_m_tdata);
                fail_cnt++;
            end else begin
                exp_res = console_out_q.pop_front();
                n_checked++;
                if (o_m_tdata[10:0] !== exp_res.cursor) begin
                    $error("cursor_index: expected %0d, got %0d",
                           exp_res.cursor, o_m_tdata[10:0]);
                    fail_cnt++;
                end
                if (o_m_tdata[26:11] !== exp_res.rdata) begin
                    $error("read_data: expected %h, got %h", exp_res.rdata, o_m_tdata[26:11]);
                    fail_cnt++;
                end
                if (o_m_tdata[27] !== exp_res.scrolled) begin
                    $error("scrolled: expected %0b, got %0b", exp_res.scrolled, o_m_tdata[27]);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        int           r;
        int           i;
        console_res_t typed_res;
        logic [ATTR_W-1:0] attr_plan [6];
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        fail_cnt    = 0;
        n_items     = 0;
        n_checked   = 0;
        n_reads     = 0;
        n_clears    = 0;
        n_scrolls   = 0;
        n_cfg       = 0;
        burst_left  = 0;
        for (i = 0; i < SCR_CELLS; i++)
            shadow_cells[i] = RESET_CELL;
        shadow_row  = 0;
        shadow_col  = 0;
        shadow_attr = ATTR_RESET;
        attr_plan   = '{8'h00, 8'hFF, 8'h1F, 8'hF0, 8'($urandom), 8'($urandom)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++) begin
            typed_res.cursor   = DIRECTED[r].cur;
            typed_res.rdata    = DIRECTED[r].rd;
            typed_res.scrolled = DIRECTED[r].sc;
            push_item(DIRECTED[r].act, DIRECTED[r].ch, DIRECTED[r].idx,
                      DIRECTED[r].typed, typed_res);
        end

        // first random phase runs at the reset attribute, with the long result stall
        hold_req = 1'b1;
        run_phase(PHASE_ITEMS);
        for (i = 0; i < 6; i++) begin
            set_attribute(attr_plan[i]);
            run_phase(PHASE_ITEMS);
        end

        while (console_out_q.size() != 0)
            @(posedge i_clk);
        repeat (2100) @(posedge i_clk);

        $display("Covered %0d items: %0d reads, %0d clears, %0d scrolls, %0d attribute writes.",
                 n_items, n_reads, n_clears, n_scrolls, n_cfg);
        $display("%0d results checked, %0d mismatches.", n_checked, fail_cnt);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
